@@ rtl/core/hca_pkg.sv @@
// ----------------------------------------------------------------------------
// hca_pkg
// Shared types, codes and reset constants of the three-channel hysteresis
// alarm.
// ----------------------------------------------------------------------------
package hca_pkg;

    // Default width of samples and limits; four fraction bits in all of them.
    localparam int DEFAULT_VALUE_WIDTH = 16;

    // Hysteresis bands are always twelve bits wide, unsigned.
    localparam int BAND_WIDTH = 12;

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VOLTAGE_LOW      = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VOLTAGE_HIGH     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VOLTAGE_BAND     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CURRENT_HIGH     = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CURRENT_BAND     = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TEMPERATURE_LOW  = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TEMPERATURE_HIGH = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TEMPERATURE_BAND = 3'd7;

    // Reset values: 207.0 V, 253.0 V, 1.0 V, 25.0 A, 0.5 A, 10.0 C, 45.0 C, 1.0 C.
    localparam int RST_VOLTAGE_LOW      = 3312;
    localparam int RST_VOLTAGE_HIGH     = 4048;
    localparam int RST_VOLTAGE_BAND     = 16;
    localparam int RST_CURRENT_HIGH     = 400;
    localparam int RST_CURRENT_BAND     = 8;
    localparam int RST_TEMPERATURE_LOW  = 160;
    localparam int RST_TEMPERATURE_HIGH = 720;
    localparam int RST_TEMPERATURE_BAND = 16;

    // Channel bit positions in the masks.
    localparam int NUM_CHANNELS = 3;
    localparam int CH_VOLTAGE     = 0;
    localparam int CH_CURRENT     = 1;
    localparam int CH_TEMPERATURE = 2;

    // Logger fault codes.
    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_COMM    = 2'd1;
    localparam logic [1:0] FAULT_STORAGE = 2'd2;

    typedef enum logic [1:0] {
        ALARM_NONE = 2'd0,
        ALARM_MEAS = 2'd1,
        ALARM_COMM = 2'd2
    } alarm_code_t;

    typedef struct packed {
        alarm_code_t               alarm_code;
        logic [NUM_CHANNELS-1:0]   out_of_range_mask;
        logic [NUM_CHANNELS-1:0]   changed_mask;
        logic                      log_event;
        logic                      publish;
        logic                      led_normal;
        logic                      led_measurement;
        logic                      led_communication;
        logic                      led_storage;
    } hca_result_t;

endpackage

@@ rtl/core/hca_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// hca_cfg_regs
// Limit and hysteresis band registers, written over the configuration port.
// ----------------------------------------------------------------------------
module hca_cfg_regs #(
    parameter int VALUE_WIDTH = hca_pkg::DEFAULT_VALUE_WIDTH,
    parameter int CFG_WIDTH   = hca_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [hca_pkg::CFG_INDEX_WIDTH-1:0]    wr_index,
    input  logic [CFG_WIDTH-1:0]                   wr_data,
    output logic signed [VALUE_WIDTH-1:0]          voltage_low,
    output logic signed [VALUE_WIDTH-1:0]          voltage_high,
    output logic [hca_pkg::BAND_WIDTH-1:0]         voltage_band,
    output logic signed [VALUE_WIDTH-1:0]          current_high,
    output logic [hca_pkg::BAND_WIDTH-1:0]         current_band,
    output logic signed [VALUE_WIDTH-1:0]          temperature_low,
    output logic signed [VALUE_WIDTH-1:0]          temperature_high,
    output logic [hca_pkg::BAND_WIDTH-1:0]         temperature_band
);
    import hca_pkg::*;

    logic signed [VALUE_WIDTH-1:0] voltage_low_reg;
    logic signed [VALUE_WIDTH-1:0] voltage_high_reg;
    logic [BAND_WIDTH-1:0]         voltage_band_reg;
    logic signed [VALUE_WIDTH-1:0] current_high_reg;
    logic [BAND_WIDTH-1:0]         current_band_reg;
    logic signed [VALUE_WIDTH-1:0] temperature_low_reg;
    logic signed [VALUE_WIDTH-1:0] temperature_high_reg;
    logic [BAND_WIDTH-1:0]         temperature_band_reg;

    logic [VALUE_WIDTH-1:0] wr_value;
    logic [BAND_WIDTH-1:0]  wr_band;

    assign wr_value = wr_data[VALUE_WIDTH-1:0];
    assign wr_band  = wr_data[BAND_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voltage_low_reg      <= VALUE_WIDTH'(RST_VOLTAGE_LOW);
            voltage_high_reg     <= VALUE_WIDTH'(RST_VOLTAGE_HIGH);
            voltage_band_reg     <= BAND_WIDTH'(RST_VOLTAGE_BAND);
            current_high_reg     <= VALUE_WIDTH'(RST_CURRENT_HIGH);
            current_band_reg     <= BAND_WIDTH'(RST_CURRENT_BAND);
            temperature_low_reg  <= VALUE_WIDTH'(RST_TEMPERATURE_LOW);
            temperature_high_reg <= VALUE_WIDTH'(RST_TEMPERATURE_HIGH);
            temperature_band_reg <= BAND_WIDTH'(RST_TEMPERATURE_BAND);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_VOLTAGE_LOW:      voltage_low_reg      <= wr_value;
                REG_VOLTAGE_HIGH:     voltage_high_reg     <= wr_value;
                REG_VOLTAGE_BAND:     voltage_band_reg     <= wr_band;
                REG_CURRENT_HIGH:     current_high_reg     <= wr_value;
                REG_CURRENT_BAND:     current_band_reg     <= wr_band;
                REG_TEMPERATURE_LOW:  temperature_low_reg  <= wr_value;
                REG_TEMPERATURE_HIGH: temperature_high_reg <= wr_value;
                REG_TEMPERATURE_BAND: temperature_band_reg <= wr_band;
                default:              ;
            endcase
        end
    end

    assign voltage_low      = voltage_low_reg;
    assign voltage_high     = voltage_high_reg;
    assign voltage_band     = voltage_band_reg;
    assign current_high     = current_high_reg;
    assign current_band     = current_band_reg;
    assign temperature_low  = temperature_low_reg;
    assign temperature_high = temperature_high_reg;
    assign temperature_band = temperature_band_reg;

endmodule

@@ rtl/core/hca_window.sv @@
// ----------------------------------------------------------------------------
// hca_window
// Window comparator with hysteresis for one channel: next alarm bit from the
// present bit, the sample, the limits and the band.
// ----------------------------------------------------------------------------
module hca_window #(
    parameter int VALUE_WIDTH = hca_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                               alarm,
    input  logic signed [VALUE_WIDTH-1:0]      sample,
    input  logic signed [VALUE_WIDTH-1:0]      low,
    input  logic signed [VALUE_WIDTH-1:0]      high,
    input  logic [hca_pkg::BAND_WIDTH-1:0]     band,
    output logic                               alarm_next
);
    import hca_pkg::*;

    // Room for low + band and high - band without overflow.
    localparam int SUM_WIDTH =
        ((VALUE_WIDTH > BAND_WIDTH) ? VALUE_WIDTH : BAND_WIDTH) + 2;

    logic signed [SUM_WIDTH-1:0] sample_ext;
    logic signed [SUM_WIDTH-1:0] low_ext;
    logic signed [SUM_WIDTH-1:0] high_ext;
    logic signed [SUM_WIDTH-1:0] band_ext;
    logic signed [SUM_WIDTH-1:0] clear_low;
    logic signed [SUM_WIDTH-1:0] clear_high;
    logic                        outside;
    logic                        inside_clear;

    assign sample_ext = SUM_WIDTH'(sample);
    assign low_ext    = SUM_WIDTH'(low);
    assign high_ext   = SUM_WIDTH'(high);
    assign band_ext   = $signed(SUM_WIDTH'(band));

    assign clear_low  = low_ext + band_ext;
    assign clear_high = high_ext - band_ext;

    assign outside      = (sample < low) || (sample > high);
    assign inside_clear = (sample_ext >= clear_low) && (sample_ext <= clear_high);

    // A set alarm holds until the sample is back inside the narrowed window.
    assign alarm_next = alarm ? !inside_clear : outside;

endmodule

@@ rtl/core/three_channel_hysteresis_alarm.sv @@
// ----------------------------------------------------------------------------
// three_channel_hysteresis_alarm
// Voltage, current and temperature alarm with hysteresis, link and logger
// fault reporting, and LED drives.
// ----------------------------------------------------------------------------
// The block takes one measurement record per clock cycle while in_ready is high
// and returns one result beat per record. A record is held in the input
// register while the window comparators evaluate it; it moves into the result
// register once that register is free or drained, and the beat is presented
// from there. The alarm state carried from record to record
// is updated as each result is registered, so records may follow each other in
// every cycle and the input side keeps accepting while a result waits to be
// taken, as long as the result register is free or drained in the same cycle.
// With both registers full and the result held off, the input stalls.
// Configuration registers are written from cfg_index and cfg_data, and cfg_ready is always
// high; write them only while no record is in flight.
// ----------------------------------------------------------------------------
module three_channel_hysteresis_alarm #(
    parameter int VALUE_WIDTH = hca_pkg::DEFAULT_VALUE_WIDTH,
    localparam int CFG_WIDTH =
        (VALUE_WIDTH > hca_pkg::BAND_WIDTH) ? VALUE_WIDTH : hca_pkg::BAND_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hca_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]                cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                link_ok,
    input  logic signed [VALUE_WIDTH-1:0]       voltage_sample,
    input  logic signed [VALUE_WIDTH-1:0]       current_sample,
    input  logic signed [VALUE_WIDTH-1:0]       temperature_sample,
    input  logic [1:0]                          logger_fault,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          alarm_code,
    output logic [2:0]                          out_of_range_mask,
    output logic [2:0]                          changed_mask,
    output logic                                log_event,
    output logic                                publish,
    output logic                                led_normal,
    output logic                                led_measurement,
    output logic                                led_communication,
    output logic                                led_storage
);
    import hca_pkg::*;

    logic signed [VALUE_WIDTH-1:0] voltage_low;
    logic signed [VALUE_WIDTH-1:0] voltage_high;
    logic [BAND_WIDTH-1:0]         voltage_band;
    logic signed [VALUE_WIDTH-1:0] current_high;
    logic [BAND_WIDTH-1:0]         current_band;
    logic signed [VALUE_WIDTH-1:0] temperature_low;
    logic signed [VALUE_WIDTH-1:0] temperature_high;
    logic [BAND_WIDTH-1:0]         temperature_band;

    // Input register.
    logic                          s1_valid_reg;
    logic                          link_ok_reg;
    logic signed [VALUE_WIDTH-1:0] voltage_reg;
    logic signed [VALUE_WIDTH-1:0] current_reg;
    logic signed [VALUE_WIDTH-1:0] temperature_reg;
    logic [1:0]                    fault_reg;

    // Carried state.
    logic [NUM_CHANNELS-1:0]       channel_alarm_reg;
    logic [NUM_CHANNELS-1:0]       channel_alarm_next;
    alarm_code_t                   last_state_reg;
    logic [1:0]                    last_fault_reg;

    // Result register.
    logic                          out_valid_reg;
    hca_result_t                   result_reg;
    hca_result_t                   result_next;

    logic [NUM_CHANNELS-1:0]       window_next;
    alarm_code_t                   state_next;
    logic [NUM_CHANNELS-1:0]       changed_next;
    logic                          in_accept;
    logic                          s1_advance;

    assign cfg_ready = 1'b1;

    hca_cfg_regs #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .CFG_WIDTH   (CFG_WIDTH)
    ) u_cfg_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .wr_en            (cfg_valid && cfg_ready),
        .wr_index         (cfg_index),
        .wr_data          (cfg_data),
        .voltage_low      (voltage_low),
        .voltage_high     (voltage_high),
        .voltage_band     (voltage_band),
        .current_high     (current_high),
        .current_band     (current_band),
        .temperature_low  (temperature_low),
        .temperature_high (temperature_high),
        .temperature_band (temperature_band)
    );

    // The input stage moves on whenever the result register is empty or drained.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            link_ok_reg     <= link_ok;
            voltage_reg     <= voltage_sample;
            current_reg     <= current_sample;
            temperature_reg <= temperature_sample;
            fault_reg       <= logger_fault;
        end
    end

    hca_window #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_window_voltage (
        .alarm      (channel_alarm_reg[CH_VOLTAGE]),
        .sample     (voltage_reg),
        .low        (voltage_low),
        .high       (voltage_high),
        .band       (voltage_band),
        .alarm_next (window_next[CH_VOLTAGE])
    );

    // The current channel has no configurable lower limit; it is zero.
    hca_window #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_window_current (
        .alarm      (channel_alarm_reg[CH_CURRENT]),
        .sample     (current_reg),
        .low        ('0),
        .high       (current_high),
        .band       (current_band),
        .alarm_next (window_next[CH_CURRENT])
    );

    hca_window #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_window_temperature (
        .alarm      (channel_alarm_reg[CH_TEMPERATURE]),
        .sample     (temperature_reg),
        .low        (temperature_low),
        .high       (temperature_high),
        .band       (temperature_band),
        .alarm_next (window_next[CH_TEMPERATURE])
    );

    always_comb
    begin
        // On a link failure the channel bits are frozen.
        channel_alarm_next = link_ok_reg ? window_next : channel_alarm_reg;
        changed_next       = channel_alarm_next ^ channel_alarm_reg;

        if (!link_ok_reg)
        begin
            state_next = ALARM_COMM;
        end
        else if (|channel_alarm_next)
        begin
            state_next = ALARM_MEAS;
        end
        else
        begin
            state_next = ALARM_NONE;
        end

        result_next.alarm_code        = state_next;
        result_next.out_of_range_mask = channel_alarm_next;
        result_next.changed_mask      = changed_next;
        result_next.log_event         = |changed_next;
        result_next.publish           = (state_next != last_state_reg)
                                        || (fault_reg != last_fault_reg)
                                        || (|changed_next);
        result_next.led_normal        = (state_next == ALARM_NONE)
                                        && (fault_reg == FAULT_NONE);
        result_next.led_measurement   = (state_next == ALARM_MEAS);
        result_next.led_communication = (state_next == ALARM_COMM)
                                        || (fault_reg == FAULT_COMM);
        result_next.led_storage       = (fault_reg == FAULT_STORAGE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_alarm_reg <= '0;
            last_state_reg    <= ALARM_NONE;
            last_fault_reg    <= FAULT_NONE;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                channel_alarm_reg <= channel_alarm_next;
                last_state_reg    <= state_next;
                last_fault_reg    <= fault_reg;
                out_valid_reg     <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign alarm_code        = result_reg.alarm_code;
    assign out_of_range_mask = result_reg.out_of_range_mask;
    assign changed_mask      = result_reg.changed_mask;
    assign log_event         = result_reg.log_event;
    assign publish           = result_reg.publish;
    assign led_normal        = result_reg.led_normal;
    assign led_measurement   = result_reg.led_measurement;
    assign led_communication = result_reg.led_communication;
    assign led_storage       = result_reg.led_storage;

    // The carried channel bits always match the mask of the last result issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> (channel_alarm_reg == result_reg.out_of_range_mask))
        else $error("channel alarm state diverged from issued mask");

    // A communication alarm never reports a channel change.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.alarm_code == ALARM_COMM))
            |-> (result_reg.changed_mask == '0))
        else $error("channel change reported during link failure");

    // With the link up, a measurement alarm is shown exactly when a channel is out.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.alarm_code != ALARM_COMM))
            |-> ((result_reg.alarm_code == ALARM_MEAS)
                 == (result_reg.out_of_range_mask != '0)))
        else $error("alarm state disagrees with out-of-range mask");

    // The input side stalls only when both stages hold a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled with room in the pipeline");

endmodule

@@ verif/three_channel_hysteresis_alarm_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_channel_hysteresis_alarm_tb
// Self-checking bench for the hysteresis alarm. Records go in over a
// valid/ready channel while the result side stalls at random. A local model
// of the three window comparators predicts every result beat. Directed
// records probe each limit edge, link loss and the fault codes. Random
// phases then run under several limit settings, including inverted and
// empty windows.
// ----------------------------------------------------------------------------
module three_channel_hysteresis_alarm_tb;
    import hca_pkg::*;

    localparam int VW             = DEFAULT_VALUE_WIDTH;
    localparam int GAP_LONG_MAX   = 30;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_RECORDS  = 220;

    // The logger may report this code even though it is not defined.
    localparam logic [1:0] FAULT_UNDEFINED = 2'd3;

    typedef struct {
        logic                 link_ok;
        logic signed [VW-1:0] voltage;
        logic signed [VW-1:0] current;
        logic signed [VW-1:0] temperature;
        logic [1:0]           fault;
    } record_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [VW-1:0]              cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic                       link_ok;
    logic signed [VW-1:0]       voltage_sample;
    logic signed [VW-1:0]       current_sample;
    logic signed [VW-1:0]       temperature_sample;
    logic [1:0]                 logger_fault;
    logic                       out_valid;
    logic                       out_ready;
    logic [1:0]                 alarm_code;
    logic [2:0]                 out_of_range_mask;
    logic [2:0]                 changed_mask;
    logic                       log_event;
    logic                       publish;
    logic                       led_normal;
    logic                       led_measurement;
    logic                       led_communication;
    logic                       led_storage;

    // Local copy of the limit registers and the alarm state.
    logic signed [VW-1:0]    v_low;
    logic signed [VW-1:0]    v_high;
    logic signed [VW-1:0]    i_high;
    logic signed [VW-1:0]    t_low;
    logic signed [VW-1:0]    t_high;
    logic [BAND_WIDTH-1:0]   v_band;
    logic [BAND_WIDTH-1:0]   i_band;
    logic [BAND_WIDTH-1:0]   t_band;
    logic [NUM_CHANNELS-1:0] chan_alarm;
    alarm_code_t             prev_state;
    logic [1:0]              prev_fault;

    hca_result_t alarm_reports[$];
    int          errors;
    int          quiet_cycles;
    bit          idling;
    bit          hold_request;

    three_channel_hysteresis_alarm #(
        .VALUE_WIDTH(VW)
    ) DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .link_ok           (link_ok),
        .voltage_sample    (voltage_sample),
        .current_sample    (current_sample),
        .temperature_sample(temperature_sample),
        .logger_fault      (logger_fault),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .alarm_code        (alarm_code),
        .out_of_range_mask (out_of_range_mask),
        .changed_mask      (changed_mask),
        .log_event         (log_event),
        .publish           (publish),
        .led_normal        (led_normal),
        .led_measurement   (led_measurement),
        .led_communication (led_communication),
        .led_storage       (led_storage)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Alarm prediction
    // ------------------------------------------------------------------------
    function automatic logic window_next(logic alarm, int x, int lo, int hi, int band);
        if (!alarm)
            return (x < lo) || (x > hi);
        // An alarm clears only well inside the window.
        return !((x >= lo + band) && (x <= hi - band));
    endfunction

    function automatic hca_result_t predict_report(record_t m);
        hca_result_t             r;
        logic [NUM_CHANNELS-1:0] now;
        logic [NUM_CHANNELS-1:0] flips;
        alarm_code_t             st;
        now = chan_alarm;
        if (m.link_ok)
        begin
            now[CH_VOLTAGE]     = window_next(chan_alarm[CH_VOLTAGE], m.voltage,
                                              v_low, v_high, v_band);
            now[CH_CURRENT]     = window_next(chan_alarm[CH_CURRENT], m.current,
                                              0, i_high, i_band);
            now[CH_TEMPERATURE] = window_next(chan_alarm[CH_TEMPERATURE], m.temperature,
                                              t_low, t_high, t_band);
            st = (now != '0) ? ALARM_MEAS : ALARM_NONE;
        end
        else
        begin
            st = ALARM_COMM;
        end
        flips                = now ^ chan_alarm;
        r.alarm_code         = st;
        r.out_of_range_mask  = now;
        r.changed_mask       = flips;
        r.log_event          = |flips;
        r.publish            = (st != prev_state) || (m.fault != prev_fault) || (|flips);
        r.led_normal         = (st == ALARM_NONE) && (m.fault == FAULT_NONE);
        r.led_measurement    = (st == ALARM_MEAS);
        r.led_communication  = (st == ALARM_COMM) || (m.fault == FAULT_COMM);
        r.led_storage        = (m.fault == FAULT_STORAGE);
        chan_alarm = now;
        prev_state = st;
        prev_fault = m.fault;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic compare_field(string name, logic [2:0] want, logic [2:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_report();
        hca_result_t want;
        if (alarm_reports.size() == 0)
        begin
            errors++;
            $display("%0t: result beat with no record pending, expected none, actual state %0d",
                     $time, alarm_code);
            return;
        end
        want = alarm_reports.pop_front();
        compare_field("alarm_code", want.alarm_code, alarm_code);
        compare_field("out_of_range_mask", want.out_of_range_mask, out_of_range_mask);
        compare_field("changed_mask", want.changed_mask, changed_mask);
        compare_field("log_event", want.log_event, log_event);
        compare_field("publish", want.publish, publish);
        compare_field("led_normal", want.led_normal, led_normal);
        compare_field("led_measurement", want.led_measurement, led_measurement);
        compare_field("led_communication", want.led_communication, led_communication);
        compare_field("led_storage", want.led_storage, led_storage);
    endtask

    // Results are checked before the record of the same edge is predicted.
    always @(posedge clk)
    begin : beat_monitor
        record_t seen;
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_report();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_VOLTAGE_LOW:      v_low  = cfg_data;
                    REG_VOLTAGE_HIGH:     v_high = cfg_data;
                    REG_VOLTAGE_BAND:     v_band = cfg_data[BAND_WIDTH-1:0];
                    REG_CURRENT_HIGH:     i_high = cfg_data;
                    REG_CURRENT_BAND:     i_band = cfg_data[BAND_WIDTH-1:0];
                    REG_TEMPERATURE_LOW:  t_low  = cfg_data;
                    REG_TEMPERATURE_HIGH: t_high = cfg_data;
                    REG_TEMPERATURE_BAND: t_band = cfg_data[BAND_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                seen.link_ok     = link_ok;
                seen.voltage     = voltage_sample;
                seen.current     = current_sample;
                seen.temperature = temperature_sample;
                seen.fault       = logger_fault;
                alarm_reports.push_back(predict_report(seen));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready)
                || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("three_channel_hysteresis_alarm_tb: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (!idling)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, GAP_LONG_MAX);
    endfunction

    function automatic logic signed [VW-1:0] to_sample(int x);
        if (x < -32768)
            x = -32768;
        if (x > 32767)
            x = 32767;
        return x[VW-1:0];
    endfunction

    function automatic record_t make_record(bit link, int v, int i, int t, logic [1:0] f);
        record_t m;
        m.link_ok     = link;
        m.voltage     = to_sample(v);
        m.current     = to_sample(i);
        m.temperature = to_sample(t);
        m.fault       = f;
        return m;
    endfunction

    // Samples land around the edges of the alarm and clear windows, near the middle, or anywhere.
    function automatic logic signed [VW-1:0] near_limits(int lo, int hi, int band);
        int x;
        case ($urandom_range(0, 4))
            0:       x = lo - band - 3 + int'($urandom_range(0, 2 * band + 6));
            1:       x = hi - band - 3 + int'($urandom_range(0, 2 * band + 6));
            2:       x = (lo + hi) / 2 + int'($urandom_range(0, 20)) - 10;
            default: x = int'($urandom_range(0, 65535)) - 32768;
        endcase
        return to_sample(x);
    endfunction

    function automatic record_t random_record();
        record_t m;
        int      r;
        m.link_ok     = ($urandom_range(0, 9) != 0);
        m.voltage     = near_limits(v_low, v_high, v_band);
        m.current     = near_limits(0, i_high, i_band);
        m.temperature = near_limits(t_low, t_high, t_band);
        r = $urandom_range(0, 19);
        if (r < 14)
            m.fault = FAULT_NONE;
        else if (r < 17)
            m.fault = FAULT_COMM;
        else if (r < 19)
            m.fault = FAULT_STORAGE;
        else
            m.fault = FAULT_UNDEFINED;
        return m;
    endfunction

    function automatic int pick_band();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 63);
            1:       return $urandom_range(0, 600);
            2:       return $urandom_range(0, 4095);
            default: return 0;
        endcase
    endfunction

    // Valid stays high after the beat so that a back-to-back record only
    // changes the payload.
    task automatic send_record(record_t m);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid           <= 1'b1;
        link_ok            <= m.link_ok;
        voltage_sample     <= m.voltage;
        current_sample     <= m.current;
        temperature_sample <= m.temperature;
        logger_fault       <= m.fault;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        @(posedge clk);
        while (alarm_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_WIDTH-1:0] idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= VW'(value);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_limits(int vl, int vh, int vb, int ih, int ib,
                                  int tl, int th, int tb);
        drain_pipeline();
        write_register(REG_VOLTAGE_LOW, vl);
        write_register(REG_VOLTAGE_HIGH, vh);
        write_register(REG_VOLTAGE_BAND, vb);
        write_register(REG_CURRENT_HIGH, ih);
        write_register(REG_CURRENT_BAND, ib);
        write_register(REG_TEMPERATURE_LOW, tl);
        write_register(REG_TEMPERATURE_HIGH, th);
        write_register(REG_TEMPERATURE_BAND, tb);
    endtask

    task automatic program_random_limits();
        int lo[2];
        int hi[2];
        int swap;
        int ih;
        for (int c = 0; c < 2; c++)
        begin
            lo[c] = int'($urandom_range(0, 65535)) - 32768;
            hi[c] = lo[c] + int'($urandom_range(0, 4000));
            if (hi[c] > 32767)
                hi[c] = 32767;
            // Now and then the window is inverted.
            if ($urandom_range(0, 7) == 0)
            begin
                swap  = lo[c];
                lo[c] = hi[c];
                hi[c] = swap;
            end
        end
        if ($urandom_range(0, 7) == 0)
            ih = int'($urandom_range(0, 65535)) - 32768;
        else
            ih = $urandom_range(0, 3000);
        program_limits(lo[0], hi[0], pick_band(), ih, pick_band(), lo[1], hi[1], pick_band());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Walks each channel across both edges of its window at the reset limits.
    task automatic test_reset_limits();
        send_record(make_record(1, 3680, 160, 400, FAULT_NONE));
        send_record(make_record(1, 3311, 160, 400, FAULT_NONE));
        send_record(make_record(1, 3312, 160, 400, FAULT_NONE));
        send_record(make_record(1, 3328, 160, 400, FAULT_NONE));
        send_record(make_record(1, 4049, 160, 400, FAULT_NONE));
        send_record(make_record(1, 4033, 160, 400, FAULT_NONE));
        send_record(make_record(1, 4032, 160, 400, FAULT_NONE));
        send_record(make_record(1, 3680, -1, 400, FAULT_NONE));
        send_record(make_record(1, 3680, 7, 400, FAULT_NONE));
        send_record(make_record(1, 3680, 8, 400, FAULT_NONE));
        send_record(make_record(1, 3680, 401, 400, FAULT_NONE));
        send_record(make_record(1, 3680, 392, 400, FAULT_NONE));
        send_record(make_record(1, 3680, 160, 159, FAULT_NONE));
        send_record(make_record(1, 3680, 160, 721, FAULT_NONE));
        // Link loss keeps the temperature alarm while the samples swing.
        send_record(make_record(0, -32768, -32768, -32768, FAULT_NONE));
        send_record(make_record(0, 32767, 32767, 32767, FAULT_COMM));
        send_record(make_record(1, -32768, 32767, -32768, FAULT_COMM));
        send_record(make_record(1, 32767, -32768, 32767, FAULT_STORAGE));
        send_record(make_record(1, 3680, 160, 400, FAULT_UNDEFINED));
        send_record(make_record(1, 3680, 160, 400, FAULT_UNDEFINED));
        send_record(make_record(1, 3680, 160, 400, FAULT_NONE));
    endtask

    // Widest windows, inverted windows with full bands, and single-point ones.
    task automatic test_register_extremes();
        program_limits(-32768, 32767, 0, 32767, 0, -32768, 32767, 0);
        send_record(make_record(1, -32768, 0, 32767, FAULT_NONE));
        send_record(make_record(1, 32767, 32767, -32768, FAULT_NONE));
        repeat (8) send_record(random_record());
        program_limits(32767, -32768, 4095, -32768, 4095, 32767, -32768, 4095);
        repeat (10) send_record(random_record());
        program_limits(0, 0, 0, 0, 0, 0, 0, 0);
        send_record(make_record(1, 0, 0, 0, FAULT_NONE));
        repeat (9) send_record(random_record());
    endtask

    task automatic test_random_windows();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                program_limits(RST_VOLTAGE_LOW, RST_VOLTAGE_HIGH, RST_VOLTAGE_BAND,
                               RST_CURRENT_HIGH, RST_CURRENT_BAND, RST_TEMPERATURE_LOW,
                               RST_TEMPERATURE_HIGH, RST_TEMPERATURE_BAND);
            else
                program_random_limits();
            idling = (phase % 3 != 2);
            repeat (PHASE_RECORDS) send_record(random_record());
        end
        idling = 1'b1;
    endtask

    // The result side holds off while records keep coming, so the input stalls.
    task automatic test_result_backpressure();
        drain_pipeline();
        idling       = 1'b0;
        hold_request = 1'b1;
        repeat (40) send_record(random_record());
        idling = 1'b1;
    endtask

    initial
    begin : result_sink
        int stall;
        stall = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                stall = pick_gap();
                out_ready <= (stall == 0);
                if (stall > 0)
                    stall--;
            end
        end
    end

    initial
    begin
        errors       = 0;
        idling       = 1'b1;
        hold_request = 1'b0;
        v_low        = RST_VOLTAGE_LOW;
        v_high       = RST_VOLTAGE_HIGH;
        v_band       = RST_VOLTAGE_BAND;
        i_high       = RST_CURRENT_HIGH;
        i_band       = RST_CURRENT_BAND;
        t_low        = RST_TEMPERATURE_LOW;
        t_high       = RST_TEMPERATURE_HIGH;
        t_band       = RST_TEMPERATURE_BAND;
        chan_alarm   = '0;
        prev_state   = ALARM_NONE;
        prev_fault   = FAULT_NONE;
        rst_n              <= 1'b0;
        cfg_valid          <= 1'b0;
        cfg_index          <= REG_VOLTAGE_LOW;
        cfg_data           <= '0;
        in_valid           <= 1'b0;
        link_ok            <= 1'b0;
        voltage_sample     <= '0;
        current_sample     <= '0;
        temperature_sample <= '0;
        logger_fault       <= FAULT_NONE;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_limits();
        test_register_extremes();
        test_random_windows();
        test_result_backpressure();

        drain_pipeline();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("three_channel_hysteresis_alarm_tb: done, clean");
        else
            $display("three_channel_hysteresis_alarm_tb: done, errors");
        $finish;
    end

endmodule
